/* sv/pocg_pkg.sv */
// Shared constants, types and helper functions of the polygon outline cost grid.
`default_nettype none

package pocg_pkg;

  localparam int MAX_MAP_WIDTH  = 256;
  localparam int MAX_MAP_HEIGHT = 256;
  localparam int MAX_VERTICES   = 64;
  localparam int COORD_BITS     = 16;

  localparam int XW         = $clog2(MAX_MAP_WIDTH);
  localparam int YW         = $clog2(MAX_MAP_HEIGHT);
  localparam int GRID_DEPTH = MAX_MAP_WIDTH * MAX_MAP_HEIGHT;
  localparam int GRID_AW    = $clog2(GRID_DEPTH);
  localparam int VAW        = $clog2(MAX_VERTICES);
  localparam int VCW        = $clog2(MAX_VERTICES + 1);
  localparam int VERT_W     = 2 * COORD_BITS;

  localparam int FIELD_W    = 16;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_DIM_W  = 9;
  localparam int CFG_THR_W  = 7;

  localparam int WALK_DW = COORD_BITS + 2;
  localparam int WALK_NW = COORD_BITS + 4;
  localparam int WALK_EW = COORD_BITS + 5;

  localparam logic [CFG_DIM_W-1:0] RST_MAP_DIM  = CFG_DIM_W'(256);
  localparam logic [CFG_THR_W-1:0] RST_THRESHOLD = CFG_THR_W'(30);

  localparam logic [7:0] COST_FREE      = 8'd0;
  localparam logic [7:0] COST_SCALE_MAX = 8'd252;
  localparam logic [7:0] COST_INSCRIBED = 8'd253;
  localparam logic [7:0] COST_LETHAL    = 8'd254;
  localparam logic [7:0] COST_UNKNOWN   = 8'd255;
  localparam logic [7:0] OCC_MAX        = 8'd100;
  localparam logic [7:0] OCC_INSCRIBED  = 8'd99;
  localparam logic [7:0] OCC_LETHAL     = 8'd100;
  localparam logic [7:0] OCC_UNKNOWN    = 8'hFF;
  localparam int         MIN_POLY_VERTS = 3;

  // Scaling of costs 1..252 onto occupancies 1..98: the quotient by 251 is
  // taken as a multiplication by a rounded-up reciprocal, exact over this range.
  localparam int OCC_STEP  = 97;
  localparam int COST_SPAN = 251;
  localparam int OCC_SHIFT = 24;
  localparam int OCC_RECIP = OCC_STEP * (((1 << OCC_SHIFT) + COST_SPAN - 1) / COST_SPAN);

  typedef logic signed [COORD_BITS:0] coord_t;
  typedef logic [XW:0] eff_w_t;
  typedef logic [YW:0] eff_h_t;

  typedef enum logic [1:0] {
    OP_VERTEX = 2'd0,
    OP_END    = 2'd1,
    OP_WRITE  = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_SHORT   = 2'd2,
    ST_OUTSIDE = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_WIDTH  = 2'd0,
    CFG_MAP_HEIGHT = 2'd1,
    CFG_FREE_THR   = 2'd2,
    CFG_OCC_THR    = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_FIRST,
    S_NEXT,
    S_WALK,
    S_DRAIN
  } state_e;

  typedef struct packed {
    logic   start;
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
  } walk_cmd_t;

  typedef struct packed {
    logic   valid;
    logic   last;
    coord_t x;
    coord_t y;
  } walk_cell_t;

  function automatic logic in_map(coord_t x, coord_t y, eff_w_t w, eff_h_t h);
    return (int'(x) >= 0) && (int'(x) < int'(w)) && (int'(y) >= 0) && (int'(y) < int'(h));
  endfunction

  function automatic logic [GRID_AW-1:0] cell_addr(coord_t x, coord_t y, eff_w_t w);
    logic [XW+YW:0] lin;
    lin = (XW+YW+1)'(y[YW-1:0]) * (XW+YW+1)'(w) + (XW+YW+1)'(x[XW-1:0]);
    return lin[GRID_AW-1:0];
  endfunction

  function automatic logic [7:0] cost_of(logic [7:0] occ, logic [CFG_THR_W-1:0] free_thr,
                                         logic [CFG_THR_W-1:0] occ_thr);
    logic [7:0] c;
    if ((occ > 8'(occ_thr)) && (occ <= OCC_MAX)) begin
      c = COST_LETHAL;
    end else if (occ <= 8'(free_thr)) begin
      c = COST_FREE;
    end else begin
      c = COST_UNKNOWN;
    end
    return c;
  endfunction

  function automatic logic [7:0] occ_of(logic [7:0] c);
    logic [31:0] prod;
    logic [7:0]  r;
    prod = 32'(c - 8'd1) * 32'(OCC_RECIP);
    if (c == COST_FREE) begin
      r = 8'd0;
    end else if (c <= COST_SCALE_MAX) begin
      r = 8'd1 + 8'(prod[31:OCC_SHIFT]);
    end else if (c == COST_INSCRIBED) begin
      r = OCC_INSCRIBED;
    end else if (c == COST_LETHAL) begin
      r = OCC_LETHAL;
    end else begin
      r = OCC_UNKNOWN;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* sv/pocg_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module pocg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/pocg_edge_walker.sv */
// Four-connected Bresenham edge walker that emits one outline cell per cycle.
`default_nettype none

module pocg_edge_walker
  import pocg_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire walk_cmd_t  cmd_i,
  output walk_cell_t      cell_o
);

  logic                      busy_q, busy_d;
  coord_t                    px_q, px_d, py_q, py_d;
  logic                      sx_q, sx_d, sy_q, sy_d;
  logic signed [WALK_EW-1:0] err_q, err_d;
  logic [WALK_NW-1:0]        n_q, n_d;
  logic [WALK_EW-1:0]        dx2_q, dx2_d, dy2_q, dy2_d;

  logic signed [WALK_DW-1:0] dfx, dfy;
  logic [WALK_DW-1:0]        adx, ady;

  always_comb begin
    dfx = WALK_DW'(cmd_i.x1) - WALK_DW'(cmd_i.x0);
    dfy = WALK_DW'(cmd_i.y1) - WALK_DW'(cmd_i.y0);
    adx = dfx[WALK_DW-1] ? WALK_DW'(-dfx) : WALK_DW'(dfx);
    ady = dfy[WALK_DW-1] ? WALK_DW'(-dfy) : WALK_DW'(dfy);

    busy_d = busy_q;
    px_d   = px_q;
    py_d   = py_q;
    sx_d   = sx_q;
    sy_d   = sy_q;
    err_d  = err_q;
    n_d    = n_q;
    dx2_d  = dx2_q;
    dy2_d  = dy2_q;

    if (cmd_i.start) begin
      busy_d = 1'b1;
      px_d   = cmd_i.x0;
      py_d   = cmd_i.y0;
      sx_d   = cmd_i.x1 > cmd_i.x0;
      sy_d   = cmd_i.y1 > cmd_i.y0;
      err_d  = $signed(WALK_EW'(adx)) - $signed(WALK_EW'(ady));
      n_d    = WALK_NW'(adx) + WALK_NW'(ady) + WALK_NW'(1);
      dx2_d  = WALK_EW'(adx) << 1;
      dy2_d  = WALK_EW'(ady) << 1;
    end else if (busy_q) begin
      if (err_q > 0) begin
        px_d  = sx_q ? px_q + coord_t'(1) : px_q - coord_t'(1);
        err_d = err_q - $signed(dy2_q);
      end else begin
        py_d  = sy_q ? py_q + coord_t'(1) : py_q - coord_t'(1);
        err_d = err_q + $signed(dx2_q);
      end
      n_d = n_q - WALK_NW'(1);
      if (n_q == WALK_NW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q  <= px_d;
    py_q  <= py_d;
    sx_q  <= sx_d;
    sy_q  <= sy_d;
    err_q <= err_d;
    n_q   <= n_d;
    dx2_q <= dx2_d;
    dy2_q <= dy2_d;
  end

  always_comb begin
    cell_o.valid = busy_q;
    cell_o.last  = busy_q && (n_q == WALK_NW'(1));
    cell_o.x     = px_q;
    cell_o.y     = py_q;
  end

endmodule

`default_nettype wire

/* sv/polygon_outline_cost_grid.sv */
// Top level: cost grid and vertex memories, op sequencer and outline writer.
// Vertex ops, writes, short polygons and off-map accesses give their result in the cycle after
// acceptance; a read passes the registered grid port and then the result register.
// Closing a polygon fetches the first vertex and then, per edge, walks its outline cells and
// fetches its end vertex or, after the closing edge, drains the last outline write.
// One item is in work at a time. Reset clears control state and the configuration to its
// default values; grid and vertex contents stay undefined until written.
`default_nettype none

module polygon_outline_cost_grid
  import pocg_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // coord_x, coord_y, occupancy_in
  input  wire logic [1:0]            s_axis_tuser_i,  // opcode
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o,  // cost_out, occupancy_out, status, zeros
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [CFG_DIM_W-1:0] width_q, height_q;
  logic [CFG_THR_W-1:0] free_thr_q, occ_thr_q;

  state_e               state_q, state_d;
  logic [VCW-1:0]       vcount_q, vcount_d;
  logic [VAW-1:0]       idx_q, idx_d, last_idx_q, last_idx_d;
  logic                 closing_q, closing_d;
  coord_t               first_x_q, first_x_d, first_y_q, first_y_d;
  coord_t               prev_x_q, prev_x_d, prev_y_q, prev_y_d;

  logic                 out_valid_q, out_valid_d;
  logic [7:0]           out_cost_q, out_cost_d, out_occ_q, out_occ_d;
  status_e              out_status_q, out_status_d;
  logic                 out_load;

  logic                 mark_we_q;
  logic [GRID_AW-1:0]   mark_addr_q;

  eff_w_t               eff_w;
  eff_h_t               eff_h;
  op_e                  in_op;
  coord_t               in_x, in_y;
  logic [7:0]           in_occ;
  logic [COORD_BITS-1:0] in_x_raw, in_y_raw;
  logic                 in_fire, in_inside;
  logic [GRID_AW-1:0]   in_addr;

  logic                 op_grid_we, grid_we, grid_re;
  logic [GRID_AW-1:0]   grid_waddr;
  logic [7:0]           grid_wdata, grid_rdata;
  logic                 vram_we, vram_re;
  logic [VAW-1:0]       vram_waddr, vram_raddr;
  logic [VERT_W-1:0]    vram_rdata;
  coord_t               rd_x, rd_y;

  walk_cmd_t            walk_cmd;
  walk_cell_t           walk_cell;

  assign eff_w = (int'(width_q) > MAX_MAP_WIDTH) ? eff_w_t'(MAX_MAP_WIDTH) : eff_w_t'(width_q);
  assign eff_h = (int'(height_q) > MAX_MAP_HEIGHT) ?
                 eff_h_t'(MAX_MAP_HEIGHT) : eff_h_t'(height_q);

  assign in_op     = op_e'(s_axis_tuser_i);
  assign in_x_raw  = COORD_BITS'(s_axis_tdata_i[FIELD_W-1:0]);
  assign in_y_raw  = COORD_BITS'(s_axis_tdata_i[2*FIELD_W-1:FIELD_W]);
  assign in_x      = coord_t'($signed(in_x_raw));
  assign in_y      = coord_t'($signed(in_y_raw));
  assign in_occ    = s_axis_tdata_i[IN_DATA_W-1:2*FIELD_W];
  assign in_inside = in_map(in_x, in_y, eff_w, eff_h);
  assign in_addr   = cell_addr(in_x, in_y, eff_w);
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;

  assign rd_x = coord_t'($signed(vram_rdata[COORD_BITS-1:0]));
  assign rd_y = coord_t'($signed(vram_rdata[VERT_W-1:COORD_BITS]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= RST_MAP_DIM;
      height_q   <= RST_MAP_DIM;
      free_thr_q <= RST_THRESHOLD;
      occ_thr_q  <= RST_THRESHOLD;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAP_WIDTH:  width_q    <= CFG_DIM_W'(cfg_data_i);
        CFG_MAP_HEIGHT: height_q   <= CFG_DIM_W'(cfg_data_i);
        CFG_FREE_THR:   free_thr_q <= CFG_THR_W'(cfg_data_i);
        CFG_OCC_THR:    occ_thr_q  <= CFG_THR_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d         = state_q;
    vcount_d        = vcount_q;
    idx_d           = idx_q;
    last_idx_d      = last_idx_q;
    closing_d       = closing_q;
    first_x_d       = first_x_q;
    first_y_d       = first_y_q;
    prev_x_d        = prev_x_q;
    prev_y_d        = prev_y_q;
    out_load        = 1'b0;
    out_cost_d      = COST_FREE;
    out_occ_d       = 8'd0;
    out_status_d    = ST_OK;
    s_axis_tready_o = 1'b0;
    op_grid_we      = 1'b0;
    grid_re         = 1'b0;
    vram_we         = 1'b0;
    vram_waddr      = vcount_q[VAW-1:0];
    vram_re         = 1'b0;
    vram_raddr      = idx_q;
    walk_cmd        = '0;

    case (state_q)
      S_IDLE: begin
        s_axis_tready_o = !out_valid_q || m_axis_tready_i;
        if (in_fire) begin
          case (in_op)
            OP_VERTEX: begin
              out_load = 1'b1;
              if (vcount_q < VCW'(MAX_VERTICES)) begin
                vram_we  = 1'b1;
                vcount_d = vcount_q + VCW'(1);
              end else begin
                out_status_d = ST_FULL;
              end
            end
            OP_END: begin
              vcount_d = '0;
              if (vcount_q < VCW'(MIN_POLY_VERTS)) begin
                out_load     = 1'b1;
                out_status_d = ST_SHORT;
              end else begin
                vram_re    = 1'b1;
                vram_raddr = '0;
                last_idx_d = VAW'(vcount_q - VCW'(1));
                closing_d  = 1'b0;
                state_d    = S_FIRST;
              end
            end
            OP_WRITE: begin
              out_load = 1'b1;
              if (in_inside) begin
                op_grid_we = 1'b1;
              end else begin
                out_status_d = ST_OUTSIDE;
              end
            end
            OP_READ: begin
              if (in_inside) begin
                grid_re = 1'b1;
                state_d = S_READ;
              end else begin
                out_load     = 1'b1;
                out_status_d = ST_OUTSIDE;
              end
            end
            default: ;
          endcase
        end
      end
      S_READ: begin
        out_load   = 1'b1;
        out_cost_d = grid_rdata;
        out_occ_d  = occ_of(grid_rdata);
        state_d    = S_IDLE;
      end
      S_FIRST: begin
        first_x_d  = rd_x;
        first_y_d  = rd_y;
        prev_x_d   = rd_x;
        prev_y_d   = rd_y;
        vram_re    = 1'b1;
        vram_raddr = VAW'(1);
        idx_d      = VAW'(1);
        state_d    = S_NEXT;
      end
      S_NEXT: begin
        walk_cmd.start = 1'b1;
        walk_cmd.x0    = prev_x_q;
        walk_cmd.y0    = prev_y_q;
        walk_cmd.x1    = rd_x;
        walk_cmd.y1    = rd_y;
        prev_x_d       = rd_x;
        prev_y_d       = rd_y;
        state_d        = S_WALK;
      end
      S_WALK: begin
        if (walk_cell.last) begin
          if (closing_q) begin
            state_d = S_DRAIN;
          end else if (idx_q == last_idx_q) begin
            // The closing edge runs from the last vertex back to the first one.
            walk_cmd.start = 1'b1;
            walk_cmd.x0    = prev_x_q;
            walk_cmd.y0    = prev_y_q;
            walk_cmd.x1    = first_x_q;
            walk_cmd.y1    = first_y_q;
            closing_d      = 1'b1;
          end else begin
            idx_d      = idx_q + VAW'(1);
            vram_re    = 1'b1;
            vram_raddr = idx_q + VAW'(1);
            state_d    = S_NEXT;
          end
        end
      end
      S_DRAIN: begin
        out_load  = 1'b1;
        closing_d = 1'b0;
        state_d   = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && !m_axis_tready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vcount_q    <= '0;
      closing_q   <= 1'b0;
      out_valid_q <= 1'b0;
      mark_we_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      vcount_q    <= vcount_d;
      closing_q   <= closing_d;
      out_valid_q <= out_valid_d;
      mark_we_q   <= walk_cell.valid && in_map(walk_cell.x, walk_cell.y, eff_w, eff_h);
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    last_idx_q  <= last_idx_d;
    first_x_q   <= first_x_d;
    first_y_q   <= first_y_d;
    prev_x_q    <= prev_x_d;
    prev_y_q    <= prev_y_d;
    mark_addr_q <= cell_addr(walk_cell.x, walk_cell.y, eff_w);
    if (out_load) begin
      out_cost_q   <= out_cost_d;
      out_occ_q    <= out_occ_d;
      out_status_q <= out_status_d;
    end
  end

  assign grid_we    = op_grid_we || mark_we_q;
  assign grid_waddr = mark_we_q ? mark_addr_q : in_addr;
  assign grid_wdata = mark_we_q ? COST_LETHAL : cost_of(in_occ, free_thr_q, occ_thr_q);

  pocg_ram #(
    .WIDTH (8),
    .DEPTH (GRID_DEPTH)
  ) u_grid_ram (
    .clk_i   (clk_i),
    .we_i    (grid_we),
    .waddr_i (grid_waddr),
    .wdata_i (grid_wdata),
    .re_i    (grid_re),
    .raddr_i (in_addr),
    .rdata_o (grid_rdata)
  );

  pocg_ram #(
    .WIDTH (VERT_W),
    .DEPTH (MAX_VERTICES)
  ) u_vertex_ram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (vram_waddr),
    .wdata_i ({in_y_raw, in_x_raw}),
    .re_i    (vram_re),
    .raddr_i (vram_raddr),
    .rdata_o (vram_rdata)
  );

  pocg_edge_walker u_walker (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (walk_cmd),
    .cell_o (walk_cell)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_status_q, out_occ_q, out_cost_q};

  a_mark_only_in_walk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mark_we_q |-> (state_q == S_WALK || state_q == S_NEXT || state_q == S_DRAIN))
    else $error("outline write outside of a polygon walk");

  a_no_result_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || m_axis_tready_i))
    else $error("result register loaded while a result is pending");

  a_vcount_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vcount_q <= VCW'(MAX_VERTICES))
    else $error("vertex count beyond buffer depth");

  a_walk_start_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_cmd.start |-> (!walk_cell.valid || walk_cell.last))
    else $error("edge started while the walker is mid-edge");

  a_walk_ends_in_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DRAIN) |=> (out_valid_q && state_q == S_IDLE && !mark_we_q))
    else $error("polygon result not delivered after the last outline write");

endmodule

`default_nettype wire
